>>> rtl/text_token_scanner_unit_macros.svh
// Assertion macros shared by the scanner checker.
`ifndef TEXT_TOKEN_SCANNER_UNIT_MACROS_SVH
`define TEXT_TOKEN_SCANNER_UNIT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define TTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define TTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tts_pkg.sv
// Shared types, codes and helpers of the text token scanner.
package tts_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned MAX_RES  = 4;
   localparam int unsigned CNT_W    = 3;
   localparam int unsigned IDX_W    = 2;

   localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EOT  = 2'd2;

   localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
   localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_APOS   = 8'h27;
   localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;

   typedef enum logic [2:0] {
      MODE_SKIP    = 3'd0,
      MODE_SLASH   = 3'd1,
      MODE_COMMENT = 3'd2,
      MODE_QUOTE   = 3'd3,
      MODE_WORD    = 3'd4
   } mode_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
   } result_type;

   typedef struct packed {
      result_type [MAX_RES-1:0] res;
      logic [CNT_W-1:0]         count;
   } decode_type;

   function automatic logic is_single(input logic [BYTE_W-1:0] c);
      return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAREN) ||
             (c == CH_RPAREN) || (c == CH_APOS) || (c == CH_COLON);
   endfunction

   function automatic result_type mk_byte(input logic [BYTE_W-1:0] c);
      result_type r;
      r.kind = KIND_BYTE;
      r.data = c;
      return r;
   endfunction

   function automatic result_type mk_mark(input logic [KIND_W-1:0] k);
      result_type r;
      r.kind = k;
      r.data = '0;
      return r;
   endfunction

endpackage

>>> rtl/tts_decode.sv
// Per-byte decode: scan mode transition and the list of result words.
module tts_decode (
   input  tts_pkg::mode_type          mode,
   input  logic [tts_pkg::BYTE_W-1:0] c,
   output tts_pkg::mode_type          mode_next,
   output tts_pkg::decode_type        dec
);

   logic                             is_nul;
   logic                             is_ws;
   logic                             is_sgl;
   tts_pkg::result_type [2:0]        w;
   logic [tts_pkg::CNT_W-1:0]        wn;
   tts_pkg::mode_type                w_mode;

   assign is_nul = (c == tts_pkg::CH_NUL);
   assign is_ws  = !is_nul && (c <= tts_pkg::CH_SPACE);
   assign is_sgl = tts_pkg::is_single(c);

   // what a byte does when it follows word content
   always_comb begin
      w      = '0;
      wn     = '0;
      w_mode = tts_pkg::MODE_SKIP;
      priority if (is_nul) begin
         w[0] = tts_pkg::mk_mark(tts_pkg::KIND_END);
         w[1] = tts_pkg::mk_mark(tts_pkg::KIND_EOT);
         wn   = 3'd2;
      end else if (is_ws) begin
         w[0] = tts_pkg::mk_mark(tts_pkg::KIND_END);
         wn   = 3'd1;
      end else if (is_sgl) begin
         w[0] = tts_pkg::mk_mark(tts_pkg::KIND_END);
         w[1] = tts_pkg::mk_byte(c);
         w[2] = tts_pkg::mk_mark(tts_pkg::KIND_END);
         wn   = 3'd3;
      end else begin
         w[0]   = tts_pkg::mk_byte(c);
         wn     = 3'd1;
         w_mode = tts_pkg::MODE_WORD;
      end
   end

   // next scan mode
   always_comb begin
      mode_next = tts_pkg::MODE_SKIP;
      unique case (mode)
         tts_pkg::MODE_SLASH: begin
            mode_next = (c == tts_pkg::CH_SLASH) ? tts_pkg::MODE_COMMENT : w_mode;
         end
         tts_pkg::MODE_COMMENT: begin
            mode_next = (is_nul || c == tts_pkg::CH_NL) ? tts_pkg::MODE_SKIP
                                                         : tts_pkg::MODE_COMMENT;
         end
         tts_pkg::MODE_QUOTE: begin
            mode_next = (is_nul || c == tts_pkg::CH_QUOTE) ? tts_pkg::MODE_SKIP
                                                           : tts_pkg::MODE_QUOTE;
         end
         tts_pkg::MODE_WORD: begin
            mode_next = w_mode;
         end
         default: begin
            priority if (is_nul || is_ws || is_sgl) mode_next = tts_pkg::MODE_SKIP;
            else if (c == tts_pkg::CH_SLASH)        mode_next = tts_pkg::MODE_SLASH;
            else if (c == tts_pkg::CH_QUOTE)        mode_next = tts_pkg::MODE_QUOTE;
            else                                    mode_next = tts_pkg::MODE_WORD;
         end
      endcase
   end

   // result words
   always_comb begin
      dec = '0;
      unique case (mode)
         tts_pkg::MODE_SLASH: begin
            if (c != tts_pkg::CH_SLASH) begin
               dec.res[0] = tts_pkg::mk_byte(tts_pkg::CH_SLASH);
               dec.res[1] = w[0];
               dec.res[2] = w[1];
               dec.res[3] = w[2];
               dec.count  = wn + 3'd1;
            end
         end
         tts_pkg::MODE_COMMENT: begin
            if (is_nul) begin
               dec.res[0] = tts_pkg::mk_mark(tts_pkg::KIND_EOT);
               dec.count  = 3'd1;
            end
         end
         tts_pkg::MODE_QUOTE: begin
            priority if (c == tts_pkg::CH_QUOTE) begin
               dec.res[0] = tts_pkg::mk_mark(tts_pkg::KIND_END);
               dec.count  = 3'd1;
            end else if (is_nul) begin
               dec.res[0] = tts_pkg::mk_mark(tts_pkg::KIND_END);
               dec.res[1] = tts_pkg::mk_mark(tts_pkg::KIND_EOT);
               dec.count  = 3'd2;
            end else begin
               dec.res[0] = tts_pkg::mk_byte(c);
               dec.count  = 3'd1;
            end
         end
         tts_pkg::MODE_WORD: begin
            dec.res[0] = w[0];
            dec.res[1] = w[1];
            dec.res[2] = w[2];
            dec.count  = wn;
         end
         default: begin
            priority if (is_nul) begin
               dec.res[0] = tts_pkg::mk_mark(tts_pkg::KIND_EOT);
               dec.count  = 3'd1;
            end else if (is_ws || c == tts_pkg::CH_SLASH || c == tts_pkg::CH_QUOTE) begin
               dec.count  = 3'd0;
            end else if (is_sgl) begin
               dec.res[0] = tts_pkg::mk_byte(c);
               dec.res[1] = tts_pkg::mk_mark(tts_pkg::KIND_END);
               dec.count  = 3'd2;
            end else begin
               dec.res[0] = tts_pkg::mk_byte(c);
               dec.count  = 3'd1;
            end
         end
      endcase
   end

endmodule

>>> rtl/text_token_scanner_unit.sv
// Top level of the streaming text token scanner.
// Text enters one byte per word on req_; byte 0 ends a text and the next byte
// starts a new one. Token bytes leave on rsp_ as they are seen, with an
// end-of-token marker after each token and an end-of-text marker for byte 0;
// whitespace, line comments and the quotes around strings give no output.
// Rate: one input byte per cycle while each byte yields at most one word and
// rsp_tready is high; a byte that yields N words (up to four) holds the input
// until its last word leaves the result register, which sends one word per
// cycle while rsp_tready is high. Bytes with no result pass at one per cycle.
// Words are registered; rsp_tlast marks the last word caused by one input byte.
module text_token_scanner_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [tts_pkg::BYTE_W-1:0]  req_tdata,   // [7:0] text_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [tts_pkg::BYTE_W-1:0]  rsp_tdata,   // [7:0] token_byte
   output logic [tts_pkg::KIND_W-1:0]  rsp_tuser,   // [1:0] kind
   output logic                        rsp_tlast    // last_of_run
);

   // scan mode carried between bytes
   tts_pkg::mode_type   mode_ff, mode_in;
   tts_pkg::mode_type   mode_dec;
   tts_pkg::decode_type dec;

   // result list of the byte being handed out, read pointer and words left
   tts_pkg::result_type [tts_pkg::MAX_RES-1:0] list_ff, list_in;
   logic [tts_pkg::IDX_W-1:0] rd_ff, rd_in;
   logic [tts_pkg::CNT_W-1:0] left_ff, left_in;

   logic take;
   logic accept;

   tts_decode u_decode (
      .mode      (mode_ff),
      .c         (req_tdata),
      .mode_next (mode_dec),
      .dec       (dec)
   );

   assign rsp_tvalid = (left_ff != '0);
   assign take       = rsp_tvalid && rsp_tready;
   // a new byte may enter once the list is empty or its last word leaves now
   assign req_tready = (left_ff == '0) || ((left_ff == 3'd1) && take);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tuser = list_ff[rd_ff].kind;
   assign rsp_tdata = list_ff[rd_ff].data;
   assign rsp_tlast = (left_ff == 3'd1);

   always_comb begin
      mode_in = mode_ff;
      list_in = list_ff;
      rd_in   = rd_ff;
      left_in = left_ff;
      priority if (accept) begin
         mode_in = mode_dec;
         list_in = dec.res;
         rd_in   = '0;
         left_in = dec.count;
      end else if (take) begin
         rd_in   = rd_ff + 2'd1;
         left_in = left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tts_pkg::MODE_SKIP;
         rd_ff   <= '0;
         left_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         rd_ff   <= rd_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      list_ff <= list_in;
   end

endmodule

>>> rtl/tts_checker.sv
// Port-level checks of the scanner, bound to the top level.
`include "text_token_scanner_unit_macros.svh"

module tts_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [tts_pkg::BYTE_W-1:0]  rsp_tdata,
   input logic [tts_pkg::KIND_W-1:0]  rsp_tuser,
   input logic                        rsp_tlast
);

   `TTS_ASSERT(a_mark_no_data, clock, reset,
      !(rsp_tvalid && rsp_tuser != tts_pkg::KIND_BYTE) || rsp_tdata == '0,
      "marker word carries nonzero data")
   `TTS_ASSERT(a_kind_legal, clock, reset,
      !rsp_tvalid || rsp_tuser == tts_pkg::KIND_BYTE || rsp_tuser == tts_pkg::KIND_END ||
      rsp_tuser == tts_pkg::KIND_EOT,
      "illegal result kind")
   `TTS_ASSERT(a_eot_last, clock, reset,
      !(rsp_tvalid && rsp_tuser == tts_pkg::KIND_EOT) || rsp_tlast,
      "end of text is not last of its run")
   `TTS_ASSERT(a_busy_no_ready, clock, reset,
      !(rsp_tvalid && !rsp_tlast) || !req_tready,
      "input ready while more than one word is pending")
   `TTS_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled result changed")

endmodule

bind text_token_scanner_unit tts_checker u_tts_checker (.*);

>>> sim/text_token_scanner_unit_tb.sv
// Self-checking testbench for the text token scanner: directed and random texts.
module text_token_scanner_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving on either side
   localparam int HOLD_START     = 120;   // receiver cycle that opens the long hold-off
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 16;
   localparam int TEXT_ITEMS     = 160;   // least text bytes before the closing byte 0, directed part included

   // One expected result word: kind, token byte, last word of the input byte.
   typedef struct packed {
      logic [tts_pkg::KIND_W-1:0] kind;
      logic [tts_pkg::BYTE_W-1:0] data;
      logic                       last;
   } token_word_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [tts_pkg::BYTE_W-1:0] req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [tts_pkg::BYTE_W-1:0] rsp_tdata;
   logic [tts_pkg::KIND_W-1:0] rsp_tuser;
   logic                       rsp_tlast;

   logic [tts_pkg::BYTE_W-1:0] text_q[$];     // text bytes not yet offered
   token_word_type             token_q[$];    // predicted result words, oldest first
   token_word_type             step_q[$];     // words caused by the byte being predicted
   tts_pkg::mode_type          scan_state = tts_pkg::MODE_SKIP;
   int                         error_cnt  = 0;

   text_token_scanner_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Scanner prediction
   // ---------------------------------------------------------------------

   // Characters that form a token on their own and cut a word short.
   function automatic logic is_punct(input logic [tts_pkg::BYTE_W-1:0] c);
      return c inside {tts_pkg::CH_LBRACE, tts_pkg::CH_RBRACE, tts_pkg::CH_LPAREN,
                       tts_pkg::CH_RPAREN, tts_pkg::CH_APOS, tts_pkg::CH_COLON};
   endfunction

   function automatic void put_token_word(input logic [tts_pkg::KIND_W-1:0] k,
                                          input logic [tts_pkg::BYTE_W-1:0] d);
      token_word_type w;
      w.kind = k;
      w.data = (k == tts_pkg::KIND_BYTE) ? d : '0;
      w.last = 1'b0;
      step_q.push_back(w);
   endfunction

   // A byte that follows word content (also a held slash once it is released).
   function automatic void close_or_extend_word(input logic [tts_pkg::BYTE_W-1:0] c);
      if (c == tts_pkg::CH_NUL) begin
         put_token_word(tts_pkg::KIND_END, '0);
         put_token_word(tts_pkg::KIND_EOT, '0);
         scan_state = tts_pkg::MODE_SKIP;
      end else if (c <= tts_pkg::CH_SPACE) begin
         put_token_word(tts_pkg::KIND_END, '0);
         scan_state = tts_pkg::MODE_SKIP;
      end else if (is_punct(c)) begin
         put_token_word(tts_pkg::KIND_END, '0);
         put_token_word(tts_pkg::KIND_BYTE, c);
         put_token_word(tts_pkg::KIND_END, '0);
         scan_state = tts_pkg::MODE_SKIP;
      end else begin
         put_token_word(tts_pkg::KIND_BYTE, c);
         scan_state = tts_pkg::MODE_WORD;
      end
   endfunction

   // Advances the scan state by one text byte and queues the words it causes.
   function automatic void scan_text_byte(input logic [tts_pkg::BYTE_W-1:0] c);
      step_q.delete();
      case (scan_state)
         tts_pkg::MODE_SLASH: begin
            if (c == tts_pkg::CH_SLASH) begin
               scan_state = tts_pkg::MODE_COMMENT;
            end else begin
               // held slash is released as the first byte of a word
               put_token_word(tts_pkg::KIND_BYTE, tts_pkg::CH_SLASH);
               close_or_extend_word(c);
            end
         end
         tts_pkg::MODE_COMMENT: begin
            if (c == tts_pkg::CH_NUL) begin
               put_token_word(tts_pkg::KIND_EOT, '0);
               scan_state = tts_pkg::MODE_SKIP;
            end else if (c == tts_pkg::CH_NL) begin
               scan_state = tts_pkg::MODE_SKIP;
            end
         end
         tts_pkg::MODE_QUOTE: begin
            if (c == tts_pkg::CH_QUOTE) begin
               put_token_word(tts_pkg::KIND_END, '0);
               scan_state = tts_pkg::MODE_SKIP;
            end else if (c == tts_pkg::CH_NUL) begin
               put_token_word(tts_pkg::KIND_END, '0);
               put_token_word(tts_pkg::KIND_EOT, '0);
               scan_state = tts_pkg::MODE_SKIP;
            end else begin
               put_token_word(tts_pkg::KIND_BYTE, c);
            end
         end
         tts_pkg::MODE_WORD: begin
            close_or_extend_word(c);
         end
         default: begin
            scan_state = tts_pkg::MODE_SKIP;
            if (c == tts_pkg::CH_NUL) begin
               put_token_word(tts_pkg::KIND_EOT, '0);
            end else if (c <= tts_pkg::CH_SPACE) begin
               // whitespace between tokens
            end else if (c == tts_pkg::CH_SLASH) begin
               scan_state = tts_pkg::MODE_SLASH;
            end else if (c == tts_pkg::CH_QUOTE) begin
               scan_state = tts_pkg::MODE_QUOTE;
            end else if (is_punct(c)) begin
               put_token_word(tts_pkg::KIND_BYTE, c);
               put_token_word(tts_pkg::KIND_END, '0);
            end else begin
               put_token_word(tts_pkg::KIND_BYTE, c);
               scan_state = tts_pkg::MODE_WORD;
            end
         end
      endcase
      if (step_q.size() > 0) begin
         step_q[step_q.size()-1].last = 1'b1;
      end
      foreach (step_q[i]) begin
         token_q.push_back(step_q[i]);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Random text helpers
   // ---------------------------------------------------------------------

   // Byte that may open a word: above space, not punctuation, slash or quote.
   function automatic logic [tts_pkg::BYTE_W-1:0] word_head_byte();
      logic [tts_pkg::BYTE_W-1:0] c;
      do begin
         c = 8'($urandom_range(33, 255));
      end while (is_punct(c) || c == tts_pkg::CH_SLASH || c == tts_pkg::CH_QUOTE);
      return c;
   endfunction

   // Byte that continues a word; slash and quote are plain word bytes here.
   function automatic logic [tts_pkg::BYTE_W-1:0] word_body_byte();
      logic [tts_pkg::BYTE_W-1:0] c;
      do begin
         c = 8'($urandom_range(33, 255));
      end while (is_punct(c));
      return c;
   endfunction

   function automatic logic [tts_pkg::BYTE_W-1:0] punct_byte();
      case ($urandom_range(0, 5))
         0:       return tts_pkg::CH_LBRACE;
         1:       return tts_pkg::CH_RBRACE;
         2:       return tts_pkg::CH_LPAREN;
         3:       return tts_pkg::CH_RPAREN;
         4:       return tts_pkg::CH_APOS;
         default: return tts_pkg::CH_COLON;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Sender: bursts of random length, random gaps in between
   // ---------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_text
      logic                       nxt_valid;
      logic [tts_pkg::BYTE_W-1:0] nxt_data;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         nxt_valid = req_tvalid;
         nxt_data  = req_tdata;
         // current word is gone (or none was offered): pick what comes next
         if (!req_tvalid || req_tready) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (text_q.size() > 0) begin
               nxt_data  = text_q.pop_front();
               nxt_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // new burst; about a third of them follow on without a gap
                  burst_left = $urandom_range(0, 20);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_tvalid <= nxt_valid;
         req_tdata  <= nxt_data;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: phases of full rate, light and heavy stalls, one long hold-off
   // ---------------------------------------------------------------------
   int rx_cycle   = 0;
   int hold_left  = 0;
   int phase_left = 0;
   int phase_kind = 0;

   always @(posedge clock) begin : drive_ready
      logic rdy;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle == HOLD_START) begin
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            // block fills up and must push back on the text input
            hold_left--;
            rdy = 1'b0;
         end else begin
            if (phase_left == 0) begin
               phase_left = $urandom_range(10, 60);
               phase_kind = $urandom_range(0, 2);
            end
            phase_left--;
            case (phase_kind)
               0:       rdy = 1'b1;
               1:       rdy = ($urandom_range(0, 3) != 0);
               default: rdy = 1'($urandom_range(0, 1));
            endcase
         end
         rsp_tready <= rdy;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on each accepted text byte, check each result word
   // ---------------------------------------------------------------------
   int idle_cycles = 0;

   function automatic void report_mismatch(input string what, input token_word_type exp_w);
      error_cnt++;
      if (error_cnt <= 10) begin
         $display("MISMATCH %s: exp kind %0d byte %02h last %0d, %s %0d byte %02h last %0d",
                  what, exp_w.kind, exp_w.data, exp_w.last,
                  "got kind", rsp_tuser, rsp_tdata, rsp_tlast);
      end
   endfunction

   always @(posedge clock) begin : watch_words
      token_word_type exp_w;
      if (!reset) begin
         // prediction first: results of this byte appear in the next cycle at the earliest
         if (req_tvalid && req_tready) begin
            scan_text_byte(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (token_q.size() == 0) begin
               exp_w = '0;
               report_mismatch("unexpected word", exp_w);
            end else begin
               exp_w = token_q.pop_front();
               if (rsp_tuser !== exp_w.kind || rsp_tdata !== exp_w.data ||
                   rsp_tlast !== exp_w.last) begin
                  report_mismatch("field", exp_w);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
               $display("text_token_scanner_unit verification failed");
               $finish;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin : run_texts
      int sel;
      int len;
      // directed: high bytes in a word, quote inside a word, punctuation ending a word
      text_q.push_back(8'hFF);
      text_q.push_back(8'h80);
      text_q.push_back(tts_pkg::CH_QUOTE);
      text_q.push_back(tts_pkg::CH_LBRACE);
      // held slash released by end of text, then by punctuation (four words)
      text_q.push_back(tts_pkg::CH_SLASH);
      text_q.push_back(tts_pkg::CH_NUL);
      text_q.push_back(tts_pkg::CH_SLASH);
      text_q.push_back(tts_pkg::CH_COLON);
      // line comment ended by newline
      text_q.push_back(tts_pkg::CH_SLASH);
      text_q.push_back(tts_pkg::CH_SLASH);
      text_q.push_back(8'h78);
      text_q.push_back(tts_pkg::CH_NL);
      // empty quotes, then an unclosed string cut by end of text
      text_q.push_back(tts_pkg::CH_QUOTE);
      text_q.push_back(tts_pkg::CH_QUOTE);
      text_q.push_back(tts_pkg::CH_QUOTE);
      text_q.push_back(8'hFF);
      text_q.push_back(8'h01);
      text_q.push_back(tts_pkg::CH_NUL);
      // whitespace extremes, then a comment cut by end of text
      text_q.push_back(tts_pkg::CH_SPACE);
      text_q.push_back(8'h01);
      text_q.push_back(tts_pkg::CH_SLASH);
      text_q.push_back(tts_pkg::CH_SLASH);
      text_q.push_back(8'h61);
      text_q.push_back(tts_pkg::CH_NUL);
      // punctuation at token start, word ended by whitespace
      text_q.push_back(tts_pkg::CH_LPAREN);
      text_q.push_back(8'h71);
      text_q.push_back(tts_pkg::CH_SPACE);

      // random: mostly well-formed tokens with random content, some noise
      while (text_q.size() < TEXT_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            len = $urandom_range(1, 3);
            repeat (len) text_q.push_back(8'($urandom_range(0, 255)));
         end else if (sel < 40) begin
            text_q.push_back(word_head_byte());
            len = $urandom_range(0, 5);
            repeat (len) text_q.push_back(word_body_byte());
         end else if (sel < 52) begin
            text_q.push_back(punct_byte());
         end else if (sel < 64) begin
            text_q.push_back(tts_pkg::CH_QUOTE);
            len = $urandom_range(0, 6);
            repeat (len) begin
               logic [tts_pkg::BYTE_W-1:0] c;
               do c = 8'($urandom_range(1, 255)); while (c == tts_pkg::CH_QUOTE);
               text_q.push_back(c);
            end
            // now and then the string is left open
            if ($urandom_range(0, 9) != 0) text_q.push_back(tts_pkg::CH_QUOTE);
         end else if (sel < 72) begin
            text_q.push_back(tts_pkg::CH_SLASH);
            text_q.push_back(tts_pkg::CH_SLASH);
            len = $urandom_range(0, 6);
            repeat (len) begin
               logic [tts_pkg::BYTE_W-1:0] c;
               do c = 8'($urandom_range(1, 255)); while (c == tts_pkg::CH_NL);
               text_q.push_back(c);
            end
            text_q.push_back(tts_pkg::CH_NL);
         end else if (sel < 80) begin
            // word that starts with a slash
            text_q.push_back(tts_pkg::CH_SLASH);
            case ($urandom_range(0, 2))
               0:       text_q.push_back(word_body_byte());
               1:       text_q.push_back(punct_byte());
               default: text_q.push_back(8'($urandom_range(1, 32)));
            endcase
         end else if (sel < 92) begin
            len = $urandom_range(1, 3);
            repeat (len) text_q.push_back(8'($urandom_range(1, 32)));
         end else begin
            text_q.push_back(tts_pkg::CH_NUL);
         end
      end
      text_q.push_back(tts_pkg::CH_NUL);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // all text offered and accepted, every predicted word seen
      do @(negedge clock);
      while (text_q.size() != 0 || req_tvalid || token_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (token_q.size() != 0) begin
         error_cnt++;
      end

      if (error_cnt == 0) begin
         $display("text_token_scanner_unit verification clean");
      end else begin
         $display("text_token_scanner_unit verification failed");
      end
      $finish;
   end

endmodule
